@@ src/rlm_pkg.sv @@
// shared types and codes for the record lock manager
package rlm_pkg;

  localparam int TRX_W = 4;
  localparam int KEY_W = 36;

  localparam int TRX_COUNT_DEF    = 16;
  localparam int LOCK_ENTRIES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 8;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  localparam logic MODE_SHARED = 1'b0;
  localparam logic MODE_EXCL   = 1'b1;

  typedef enum logic [2:0] {
    KIND_GRANTED   = 3'd0,
    KIND_WAIT      = 3'd1,
    KIND_WOKEN     = 3'd2,
    KIND_UNLOCKED  = 3'd3,
    KIND_NOT_FOUND = 3'd4,
    KIND_FULL      = 3'd5
  } kind_t;

  typedef struct packed {
    logic             op;
    logic [TRX_W-1:0] trx_id;
    logic [3:0]       table_id;
    logic [15:0]      page;
    logic [15:0]      slot;
    logic             mode;
  } req_t;

  typedef struct packed {
    kind_t            kind;
    logic [TRX_W-1:0] who;
    logic             granted_mode;
    logic             last;
  } rsp_t;

  // one waiting request in a record's queue
  typedef struct packed {
    logic [TRX_W-1:0] trx;
    logic             mode;
  } wait_t;

endpackage

@@ src/record_lock_manager.sv @@
// record lock manager: key scan, entry read-modify-write and wait queue walk
//
// Each request first scans the key memory, one entry a cycle, until it hits its key or
// passes the last entry, so the scan takes longer the later its key sits and a missing
// key walks every entry; key compares follow the registered key memory read port. An
// unlock that reads its wait queue passes through S_QRD and S_QCHK for each queue entry
// read, and every result waits while the output register is held. One request is handled
// at a time; results leave through a single output register. Entry valid bits are
// flip-flops cleared by reset, so no clearing pass is needed after reset.
module record_lock_manager #(
  parameter int TRX_COUNT    = rlm_pkg::TRX_COUNT_DEF,
  parameter int LOCK_ENTRIES = rlm_pkg::LOCK_ENTRIES_DEF,
  parameter int QUEUE_DEPTH  = rlm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rlm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rlm_pkg::rsp_t rsp
);
  import rlm_pkg::*;

  localparam int IDX_W  = $clog2(LOCK_ENTRIES);
  localparam int SCAN_W = $clog2(LOCK_ENTRIES + 1);
  localparam int HD_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = $clog2(2 * QUEUE_DEPTH);
  localparam int QA_W   = $clog2(LOCK_ENTRIES * QUEUE_DEPTH);

  typedef struct packed {
    logic [TRX_COUNT-1:0] holders;
    logic                 mode;
    logic [HD_W-1:0]      head;
    logic [CNT_W-1:0]     cnt;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ENT_RD, S_ENT, S_QRD, S_QCHK, S_EMIT2
  } state_t;

  typedef enum logic [1:0] {WK_SOLE_FIRST, WK_RUN, WK_PARTIAL} walk_t;

  // memories
  logic [KEY_W-1:0] key_mem [LOCK_ENTRIES];
  ent_t             ent_mem [LOCK_ENTRIES];
  wait_t            q_mem   [LOCK_ENTRIES * QUEUE_DEPTH];

  logic [LOCK_ENTRIES-1:0] valid;

  state_t            state;
  walk_t             wk;
  req_t              req_q;
  logic [SCAN_W-1:0] scan;
  logic              cmp_v;
  logic [IDX_W-1:0]  cmp_idx;
  logic              free_v;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  e;
  ent_t              w;
  logic [TRX_W-1:0]  pend_who;
  rsp_t              e2;

  logic [KEY_W-1:0] key_q;
  ent_t             ent_q;
  wait_t            q_q;

  logic             key_we;
  logic [IDX_W-1:0] key_wa;
  logic [KEY_W-1:0] key_wd;
  logic             ent_we;
  logic [IDX_W-1:0] ent_wa;
  ent_t             ent_wd;
  logic             q_we;
  logic [QA_W-1:0]  q_wa;
  wait_t            q_wd;

  // combinational helpers
  logic                 out_free;
  logic [IDX_W-1:0]     scan_idx;
  logic                 scan_live;
  logic [KEY_W-1:0]     req_key;
  logic                 key_hit;
  logic                 scan_end;
  logic [TRX_COUNT-1:0] bit_m;
  logic [TRX_COUNT-1:0] rest;
  logic                 is_holder;
  logic                 sole;
  logic                 rest_single;
  logic                 q_full;
  logic [SUM_W-1:0]     pos_sum;
  logic [HD_W-1:0]      pos;
  logic [QA_W-1:0]      base;
  logic [QA_W-1:0]      q_ra;
  logic [TRX_COUNT-1:0] wbit;
  logic [HD_W-1:0]      pop_head;
  logic [CNT_W-1:0]     pop_cnt;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    scan_idx    = scan[IDX_W-1:0];
    scan_live   = (scan < SCAN_W'(LOCK_ENTRIES));
    req_key     = {req_q.table_id, req_q.page, req_q.slot};
    key_hit     = cmp_v && valid[cmp_idx] && (key_q == req_key);
    scan_end    = cmp_v && (cmp_idx == IDX_W'(LOCK_ENTRIES - 1));
    bit_m       = TRX_COUNT'(1) << req_q.trx_id;
    is_holder   = |(ent_q.holders & bit_m);
    sole        = (ent_q.holders == bit_m);
    rest        = ent_q.holders & ~bit_m;
    rest_single = ((rest & (rest - TRX_COUNT'(1))) == '0);
    q_full      = (ent_q.cnt >= CNT_W'(QUEUE_DEPTH));
    pos_sum     = SUM_W'(ent_q.head) + SUM_W'(ent_q.cnt);
    if (pos_sum >= SUM_W'(QUEUE_DEPTH)) begin
      pos = HD_W'(pos_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      pos = HD_W'(pos_sum);
    end
    base     = QA_W'(e) * QA_W'(QUEUE_DEPTH);
    q_ra     = base + QA_W'(w.head);
    wbit     = TRX_COUNT'(1) << q_q.trx;
    pop_head = (w.head == HD_W'(QUEUE_DEPTH - 1)) ? '0 : w.head + HD_W'(1);
    pop_cnt  = w.cnt - CNT_W'(1);
  end

  // synchronous read ports
  always_ff @(posedge clk) begin
    key_q <= key_mem[scan_idx];
    ent_q <= ent_mem[e];
    q_q   <= q_mem[q_ra];
  end

  // write ports
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      rsp_valid <= 1'b0;
      key_we    <= 1'b0;
      ent_we    <= 1'b0;
      q_we      <= 1'b0;
      cmp_v     <= 1'b0;
      free_v    <= 1'b0;
    end else begin
      key_we <= 1'b0;
      ent_we <= 1'b0;
      q_we   <= 1'b0;
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q  <= req;
            scan   <= '0;
            cmp_v  <= 1'b0;
            free_v <= 1'b0;
            if (int'(req.trx_id) >= TRX_COUNT) begin
              e2    <= '{kind: KIND_FULL, who: req.trx_id, granted_mode: 1'b0, last: 1'b1};
              state <= S_EMIT2;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_v   <= scan_live;
          cmp_idx <= scan_idx;
          if (scan_live) begin
            scan <= scan + SCAN_W'(1);
            if (!free_v && !valid[scan_idx]) begin
              free_v   <= 1'b1;
              free_idx <= scan_idx;
            end
          end
          if (key_hit) begin
            e     <= cmp_idx;
            state <= S_ENT_RD;
          end else if (scan_end) begin
            state <= S_EMIT2;
            if (req_q.op == OP_UNLOCK) begin
              e2 <= '{kind: KIND_NOT_FOUND, who: req_q.trx_id, granted_mode: 1'b0,
                      last: 1'b1};
            end else if (!free_v) begin
              e2 <= '{kind: KIND_FULL, who: req_q.trx_id, granted_mode: 1'b0, last: 1'b1};
            end else begin
              valid[free_idx] <= 1'b1;
              key_we <= 1'b1;
              key_wa <= free_idx;
              key_wd <= req_key;
              ent_we <= 1'b1;
              ent_wa <= free_idx;
              ent_wd <= '{holders: bit_m, mode: req_q.mode, head: '0, cnt: '0};
              e2 <= '{kind: KIND_GRANTED, who: req_q.trx_id, granted_mode: req_q.mode,
                      last: 1'b1};
            end
          end
        end
        S_ENT_RD: begin
          state <= S_ENT;
        end
        S_ENT: begin
          if (out_free) begin
            ent_wa <= e;
            if (req_q.op == OP_LOCK) begin
              state <= S_EMIT2;
              priority if (is_holder && (ent_q.mode >= req_q.mode)) begin
                e2 <= '{kind: KIND_GRANTED, who: req_q.trx_id, granted_mode: ent_q.mode,
                        last: 1'b1};
              end else if (is_holder && sole) begin
                ent_we <= 1'b1;
                ent_wd <= '{holders: ent_q.holders, mode: MODE_EXCL, head: ent_q.head,
                            cnt: ent_q.cnt};
                e2 <= '{kind: KIND_GRANTED, who: req_q.trx_id, granted_mode: MODE_EXCL,
                        last: 1'b1};
              end else if (!is_holder && ent_q.cnt == '0 && ent_q.holders == '0) begin
                ent_we <= 1'b1;
                ent_wd <= '{holders: bit_m, mode: req_q.mode, head: ent_q.head,
                            cnt: ent_q.cnt};
                e2 <= '{kind: KIND_GRANTED, who: req_q.trx_id, granted_mode: req_q.mode,
                        last: 1'b1};
              end else if (!is_holder && ent_q.cnt == '0 && ent_q.mode == MODE_SHARED
                           && req_q.mode == MODE_SHARED) begin
                ent_we <= 1'b1;
                ent_wd <= '{holders: ent_q.holders | bit_m, mode: MODE_SHARED,
                            head: ent_q.head, cnt: ent_q.cnt};
                e2 <= '{kind: KIND_GRANTED, who: req_q.trx_id, granted_mode: MODE_SHARED,
                        last: 1'b1};
              end else if (q_full) begin
                e2 <= '{kind: KIND_FULL, who: req_q.trx_id, granted_mode: 1'b0, last: 1'b1};
              end else begin
                q_we   <= 1'b1;
                q_wa   <= base + QA_W'(pos);
                q_wd   <= '{trx: req_q.trx_id, mode: req_q.mode};
                ent_we <= 1'b1;
                ent_wd <= '{holders: ent_q.holders, mode: ent_q.mode, head: ent_q.head,
                            cnt: ent_q.cnt + CNT_W'(1)};
                e2 <= '{kind: KIND_WAIT, who: req_q.trx_id, granted_mode: req_q.mode,
                        last: 1'b1};
              end
            end else begin
              priority if (!is_holder) begin
                e2 <= '{kind: KIND_NOT_FOUND, who: req_q.trx_id, granted_mode: 1'b0,
                        last: 1'b1};
                state <= S_EMIT2;
              end else if (sole && ent_q.cnt == '0) begin
                // last holder gone and nobody waits: free the entry
                valid[e] <= 1'b0;
                e2 <= '{kind: KIND_UNLOCKED, who: req_q.trx_id, granted_mode: 1'b0,
                        last: 1'b1};
                state <= S_EMIT2;
              end else if (sole) begin
                rsp_valid <= 1'b1;
                rsp <= '{kind: KIND_UNLOCKED, who: req_q.trx_id, granted_mode: 1'b0,
                         last: 1'b0};
                w     <= '{holders: '0, mode: ent_q.mode, head: ent_q.head, cnt: ent_q.cnt};
                wk    <= WK_SOLE_FIRST;
                state <= S_QRD;
              end else if (rest_single && ent_q.cnt != '0) begin
                // the unlocked result waits until the head is known
                w     <= '{holders: rest, mode: ent_q.mode, head: ent_q.head, cnt: ent_q.cnt};
                wk    <= WK_PARTIAL;
                state <= S_QRD;
              end else begin
                ent_we <= 1'b1;
                ent_wd <= '{holders: rest, mode: ent_q.mode, head: ent_q.head,
                            cnt: ent_q.cnt};
                e2 <= '{kind: KIND_UNLOCKED, who: req_q.trx_id, granted_mode: 1'b0,
                        last: 1'b1};
                state <= S_EMIT2;
              end
            end
          end
        end
        S_QRD: begin
          state <= S_QCHK;
        end
        S_QCHK: begin
          if (out_free) begin
            ent_wa <= e;
            unique case (wk)
              WK_SOLE_FIRST: begin
                if (q_q.mode == MODE_EXCL) begin
                  ent_we <= 1'b1;
                  ent_wd <= '{holders: wbit, mode: MODE_EXCL, head: pop_head, cnt: pop_cnt};
                  rsp_valid <= 1'b1;
                  rsp <= '{kind: KIND_WOKEN, who: q_q.trx, granted_mode: MODE_EXCL,
                           last: 1'b1};
                  state <= S_IDLE;
                end else begin
                  w <= '{holders: wbit, mode: MODE_SHARED, head: pop_head, cnt: pop_cnt};
                  pend_who <= q_q.trx;
                  wk <= WK_RUN;
                  if (pop_cnt == '0) begin
                    ent_we <= 1'b1;
                    ent_wd <= '{holders: wbit, mode: MODE_SHARED, head: pop_head,
                                cnt: pop_cnt};
                    rsp_valid <= 1'b1;
                    rsp <= '{kind: KIND_WOKEN, who: q_q.trx, granted_mode: MODE_SHARED,
                             last: 1'b1};
                    state <= S_IDLE;
                  end else begin
                    state <= S_QRD;
                  end
                end
              end
              WK_RUN: begin
                rsp_valid <= 1'b1;
                if (q_q.mode == MODE_SHARED) begin
                  rsp <= '{kind: KIND_WOKEN, who: pend_who, granted_mode: MODE_SHARED,
                           last: 1'b0};
                  w <= '{holders: w.holders | wbit, mode: MODE_SHARED, head: pop_head,
                         cnt: pop_cnt};
                  pend_who <= q_q.trx;
                  if (pop_cnt == '0) begin
                    ent_we <= 1'b1;
                    ent_wd <= '{holders: w.holders | wbit, mode: MODE_SHARED,
                                head: pop_head, cnt: pop_cnt};
                    e2 <= '{kind: KIND_WOKEN, who: q_q.trx, granted_mode: MODE_SHARED,
                            last: 1'b1};
                    state <= S_EMIT2;
                  end else begin
                    state <= S_QRD;
                  end
                end else begin
                  // exclusive request ends the shared run
                  rsp <= '{kind: KIND_WOKEN, who: pend_who, granted_mode: MODE_SHARED,
                           last: 1'b1};
                  ent_we <= 1'b1;
                  ent_wd <= w;
                  state <= S_IDLE;
                end
              end
              WK_PARTIAL: begin
                rsp_valid <= 1'b1;
                ent_we    <= 1'b1;
                if (wbit == w.holders) begin
                  // remaining holder's own upgrade waits at the head
                  ent_wd <= '{holders: w.holders, mode: w.mode | q_q.mode, head: pop_head,
                              cnt: pop_cnt};
                  rsp <= '{kind: KIND_UNLOCKED, who: req_q.trx_id, granted_mode: 1'b0,
                           last: 1'b0};
                  e2 <= '{kind: KIND_WOKEN, who: q_q.trx, granted_mode: w.mode | q_q.mode,
                          last: 1'b1};
                  state <= S_EMIT2;
                end else begin
                  ent_wd <= w;
                  rsp <= '{kind: KIND_UNLOCKED, who: req_q.trx_id, granted_mode: 1'b0,
                           last: 1'b1};
                  state <= S_IDLE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= e2;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a queue walk only starts with a waiter present
  a_walk_has_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_QCHK) |-> (w.cnt != '0))
    else $error("queue walk on an empty queue");

  a_partial_one_holder: assert property (@(posedge clk) disable iff (rst)
    (state == S_QCHK && wk == WK_PARTIAL) |-> $onehot(w.holders))
    else $error("upgrade check with more than one holder left");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while one is in flight");

  a_more_owed: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && !rsp.last) |-> (state != S_IDLE))
    else $error("idle with results of the request still owed");

endmodule
